### design/vfv_pkg.sv
`timescale 1ns / 1ps

package vfv_pkg;

	// fixed field widths
	localparam int COORD_W   = 32;
	localparam int TYPE_W    = 6;
	localparam int MASK_W    = 64;
	localparam int FACE_W    = 6;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 3;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FACE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SOLID = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VIEWABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOLID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd4;

	// access steps: center cell, then neighbours in face bit order
	localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
	localparam logic [STEP_W-1:0] STEP_PX     = 3'd1;
	localparam logic [STEP_W-1:0] STEP_NX     = 3'd2;
	localparam logic [STEP_W-1:0] STEP_PY     = 3'd3;
	localparam logic [STEP_W-1:0] STEP_NY     = 3'd4;
	localparam logic [STEP_W-1:0] STEP_PZ     = 3'd5;
	localparam logic [STEP_W-1:0] STEP_NZ     = 3'd6;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACCESS,
		S_DRAIN,
		S_DONE
	} state_t;

endpackage

### design/voxel_face_visibility_store.sv
`timescale 1ns / 1ps
// path from accept to result valid: an item inside the chunk passes ACCESS, DRAIN, then DONE;
// an outside position or unused kind goes straight to DONE, which loads the result once the result side is free
// a new item is taken only in IDLE, after the previous result has loaded;
// the single-port store serves the center and six neighbours one access per cycle
// reset: registers clear at once, then a clearing pass writes void to all SIDE^3 cells,
// one per cycle; in_stall stays high until it ends

module voxel_face_visibility_store
	import vfv_pkg::*;
#(
	parameter int SIDE      = 16,
	parameter int TYPE_BITS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [MASK_W-1:0]           cfg_data,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [KIND_W-1:0]           kind,
	input  logic signed [COORD_W-1:0]   pos_x,
	input  logic signed [COORD_W-1:0]   pos_y,
	input  logic signed [COORD_W-1:0]   pos_z,
	input  logic [TYPE_W-1:0]           new_type,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        in_chunk,
	output logic [FACE_W-1:0]           face_mask,
	output logic [TYPE_W-1:0]           cell_type,
	output logic                        solid_hit
);

	localparam int LB    = $clog2(SIDE);
	localparam int CELLS = SIDE * SIDE * SIDE;
	localparam int AW    = $clog2(CELLS);

	// configuration registers
	logic [MASK_W-1:0]         viewable_mask_q;
	logic [MASK_W-1:0]         solid_mask_q;
	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_y_q;
	logic signed [COORD_W-1:0] origin_z_q;

	// item under work
	state_t                state_q, state_d;
	logic [KIND_W-1:0]     kind_q;
	logic [TYPE_BITS-1:0]  new_type_q;
	logic                  inside_q;
	logic [LB-1:0]         lx_q, ly_q, lz_q;
	logic [STEP_W-1:0]     step_q;
	logic [AW-1:0]         clr_cnt_q;

	// read return pipeline and gathered results
	logic                  rd_pend_s1;
	logic [STEP_W-1:0]     rd_step_s1;
	logic                  rd_ok_s1;
	logic [TYPE_BITS-1:0]  center_q;
	logic [FACE_W-1:0]     faces_q;

	// output register
	logic                  out_valid_q;
	logic                  in_chunk_q;
	logic [FACE_W-1:0]     face_mask_q;
	logic [TYPE_W-1:0]     cell_type_q;
	logic                  solid_hit_q;

	// local coordinates: exact 33-bit difference so no wrap can fake an inside hit
	logic signed [COORD_W:0] dx, dy, dz;
	logic                    pos_inside;
	logic                    accept;

	assign dx = {pos_x[COORD_W-1], pos_x} - {origin_x_q[COORD_W-1], origin_x_q};
	assign dy = {pos_y[COORD_W-1], pos_y} - {origin_y_q[COORD_W-1], origin_y_q};
	assign dz = {pos_z[COORD_W-1], pos_z} - {origin_z_q[COORD_W-1], origin_z_q};

	assign pos_inside = !dx[COORD_W] && ($unsigned(dx) < (COORD_W+1)'(SIDE))
		&& !dy[COORD_W] && ($unsigned(dy) < (COORD_W+1)'(SIDE))
		&& !dz[COORD_W] && ($unsigned(dz) < (COORD_W+1)'(SIDE));

	assign accept = in_valid && !in_stall;

	// neighbour selection for the current access step
	logic [LB-1:0] nx, ny, nz;
	logic          nb_ok;
	logic [STEP_W-1:0] last_step;

	always_comb begin
		nx    = lx_q;
		ny    = ly_q;
		nz    = lz_q;
		nb_ok = 1'b1;
		case (step_q)
			STEP_CENTER: begin
			end
			STEP_PX: begin
				if (lx_q == LB'(SIDE - 1)) nb_ok = 1'b0;
				else nx = lx_q + LB'(1);
			end
			STEP_NX: begin
				if (lx_q == '0) nb_ok = 1'b0;
				else nx = lx_q - LB'(1);
			end
			STEP_PY: begin
				if (ly_q == LB'(SIDE - 1)) nb_ok = 1'b0;
				else ny = ly_q + LB'(1);
			end
			STEP_NY: begin
				if (ly_q == '0) nb_ok = 1'b0;
				else ny = ly_q - LB'(1);
			end
			STEP_PZ: begin
				if (lz_q == LB'(SIDE - 1)) nb_ok = 1'b0;
				else nz = lz_q + LB'(1);
			end
			STEP_NZ: begin
				if (lz_q == '0) nb_ok = 1'b0;
				else nz = lz_q - LB'(1);
			end
			default: nb_ok = 1'b0;
		endcase
	end

	// face queries walk center plus six neighbours, others touch the center only
	assign last_step = (kind_q == KIND_FACE) ? STEP_NZ : STEP_CENTER;

	// cell index (x*SIDE + y)*SIDE + z; small constant multiplies
	logic [AW-1:0] cell_addr;
	assign cell_addr = (AW'(nx) * AW'(SIDE) + AW'(ny)) * AW'(SIDE) + AW'(nz);

	// store port
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [TYPE_BITS-1:0] ram_wdata;
	logic [TYPE_BITS-1:0] ram_rdata;
	logic                 ram_rd;
	logic                 load_out;

	vfv_ram #(
		.WIDTH(TYPE_BITS),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == AW'(CELLS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (pos_inside && (kind == KIND_WRITE || kind == KIND_FACE
						|| kind == KIND_SOLID)) state_d = S_ACCESS;
					else state_d = S_DONE;
				end
			end
			S_ACCESS: begin
				if (step_q == last_step) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_rd    = 1'b0;
		ram_addr  = cell_addr;
		ram_wdata = new_type_q;
		load_out  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				// void fill after reset
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = '0;
			end
			S_IDLE: in_stall = 1'b0;
			S_ACCESS: begin
				if (kind_q == KIND_WRITE) ram_we = 1'b1;
				else ram_rd = 1'b1;
			end
			S_DRAIN: begin
			end
			S_DONE: load_out = !out_valid_q || !out_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (state_q == S_ACCESS) step_q <= step_q + STEP_W'(1);
			else step_q <= STEP_CENTER;
		end
	end

	// configuration; writes beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewable_mask_q <= '0;
			solid_mask_q    <= '0;
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			origin_z_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VIEWABLE: viewable_mask_q <= cfg_data;
				REG_SOLID:    solid_mask_q    <= cfg_data;
				REG_ORIGIN_X: origin_x_q      <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y: origin_y_q      <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Z: origin_z_q      <= cfg_data[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// item capture; local coordinates only matter when inside
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			new_type_q <= new_type[TYPE_BITS-1:0];
			inside_q   <= pos_inside;
			lx_q       <= dx[LB-1:0];
			ly_q       <= dy[LB-1:0];
			lz_q       <= dz[LB-1:0];
		end
	end

	// read return tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= ram_rd;
		end
	end

	always_ff @(posedge clk) begin
		rd_step_s1 <= step_q;
		rd_ok_s1   <= nb_ok;
	end

	// gather center type and per-face show results as data returns
	logic [STEP_W-1:0] face_idx;
	assign face_idx = rd_step_s1 - STEP_W'(1);

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			if (rd_step_s1 == STEP_CENTER) center_q <= ram_rdata;
			else faces_q[face_idx] <= !(rd_ok_s1 && viewable_mask_q[TYPE_W'(ram_rdata)]);
		end
	end

	// result forming
	logic              res_in;
	logic              res_query;
	logic              center_view;
	logic              center_solid;

	assign res_in       = inside_q && (kind_q == KIND_WRITE || kind_q == KIND_FACE
		|| kind_q == KIND_SOLID);
	assign res_query    = kind_q == KIND_FACE || kind_q == KIND_SOLID;
	assign center_view  = viewable_mask_q[TYPE_W'(center_q)];
	assign center_solid = solid_mask_q[TYPE_W'(center_q)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			in_chunk_q  <= res_in;
			face_mask_q <= (res_in && kind_q == KIND_FACE && center_view) ? faces_q : '0;
			if (!res_in) cell_type_q <= '0;
			else if (kind_q == KIND_WRITE) cell_type_q <= TYPE_W'(new_type_q);
			else cell_type_q <= TYPE_W'(center_q);
			solid_hit_q <= res_in && res_query && center_solid;
		end
	end

	assign out_valid = out_valid_q;
	assign in_chunk  = in_chunk_q;
	assign face_mask = face_mask_q;
	assign cell_type = cell_type_q;
	assign solid_hit = solid_hit_q;

	// store writes only for a write item that landed inside, or the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != S_CLEAR) |-> (kind_q == KIND_WRITE && inside_q))
		else $error("store write outside a write item");

	// read data is only expected in the cycle after a read access
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q == S_ACCESS && kind_q != KIND_WRITE))
		else $error("read return without access");

	// the access walk never passes the last neighbour
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACCESS) |-> (step_q <= last_step))
		else $error("access step overrun");

	// a result only loads once the item's reads have drained
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !rd_pend_s1)
		else $error("result loaded with read outstanding");

endmodule

### design/vfv_ram.sv
`timescale 1ns / 1ps

module vfv_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

### sim/tb_voxel_face_visibility_store.sv
`timescale 1ns / 1ps

module tb_voxel_face_visibility_store;
	import vfv_pkg::*;

	localparam int SIDE = 16;
	localparam int CELLS = SIDE * SIDE * SIDE;
	// cycles with no item moving on either side before the run is given up
	// (covers the clearing pass after reset with lots of margin)
	localparam int QUIET_LIMIT = 20000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic              hit;
		logic [FACE_W-1:0] faces;
		logic [TYPE_W-1:0] ctype;
		logic              solid;
	} vox_result_t;

	// one line of the directed script: either a register write or an item
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [MASK_W-1:0]    reg_val;
		logic [KIND_W-1:0]    k;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
		logic [TYPE_W-1:0]    nt;
		logic                 pinned;
		vox_result_t          want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MASK_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic signed [COORD_W-1:0] pos_z = '0;
	logic [TYPE_W-1:0] new_type = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic in_chunk;
	logic [FACE_W-1:0] face_mask;
	logic [TYPE_W-1:0] cell_type;
	logic solid_hit;

	// shadow copy of the chunk and its registers
	logic [TYPE_W-1:0] cell_types [0:CELLS-1];
	logic [MASK_W-1:0] viewable_bits = '0;
	logic [MASK_W-1:0] solid_bits = '0;
	logic signed [COORD_W-1:0] org_x = '0;
	logic signed [COORD_W-1:0] org_y = '0;
	logic signed [COORD_W-1:0] org_z = '0;

	vox_result_t pending_results[$];
	script_row_t script[$];
	// typed-in expectation for the item currently on the input port
	logic pin_on = 1'b0;
	vox_result_t pin_res = '0;
	logic calm = 1'b0;
	int errors = 0;
	int quiet = 0;

	voxel_face_visibility_store #(
		.SIDE(SIDE),
		.TYPE_BITS(TYPE_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.new_type(new_type),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.in_chunk(in_chunk),
		.face_mask(face_mask),
		.cell_type(cell_type),
		.solid_hit(solid_hit)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (cell_types[i]) cell_types[i] = '0;
	end

	// ---------------------------------------------------------------
	// shadow chunk
	// ---------------------------------------------------------------

	function automatic logic in_range(longint x, longint y, longint z);
		return x >= 0 && x < SIDE && y >= 0 && y < SIDE && z >= 0 && z < SIDE;
	endfunction

	function automatic int cell_idx(longint x, longint y, longint z);
		return int'((x * SIDE + y) * SIDE + z);
	endfunction

	// a face shows when the neighbour is past the border or not viewable
	function automatic logic face_shows(longint x, longint y, longint z);
		if (!in_range(x, y, z))
			return 1'b1;
		return !viewable_bits[cell_types[cell_idx(x, y, z)]];
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
		case (idx)
			REG_VIEWABLE: viewable_bits = val;
			REG_SOLID:    solid_bits = val;
			REG_ORIGIN_X: org_x = val[COORD_W-1:0];
			REG_ORIGIN_Y: org_y = val[COORD_W-1:0];
			REG_ORIGIN_Z: org_z = val[COORD_W-1:0];
			default: ;
		endcase
	endfunction

	// result of one item; a write also updates the shadow chunk
	function automatic vox_result_t predict_visibility(logic [KIND_W-1:0] k,
			logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
			logic signed [COORD_W-1:0] pz, logic [TYPE_W-1:0] nt);
		longint lx, ly, lz;
		logic [TYPE_W-1:0] t;
		vox_result_t r;
		// exact local coordinates, no 32-bit wrap
		lx = longint'(px) - longint'(org_x);
		ly = longint'(py) - longint'(org_y);
		lz = longint'(pz) - longint'(org_z);
		r = '0;
		if (in_range(lx, ly, lz)) begin
			t = cell_types[cell_idx(lx, ly, lz)];
			case (k)
				KIND_WRITE: begin
					cell_types[cell_idx(lx, ly, lz)] = nt;
					r.hit = 1'b1;
					r.ctype = nt;
				end
				KIND_FACE, KIND_SOLID: begin
					r.hit = 1'b1;
					r.ctype = t;
					r.solid = solid_bits[t];
					if (k == KIND_FACE && viewable_bits[t])
						r.faces = {face_shows(lx, ly, lz - 1), face_shows(lx, ly, lz + 1),
							face_shows(lx, ly - 1, lz), face_shows(lx, ly + 1, lz),
							face_shows(lx - 1, ly, lz), face_shows(lx + 1, ly, lz)};
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// random choices
	// ---------------------------------------------------------------

	// mostly no gap, some short, a few long; none in a calm stretch
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_origin();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return C_MAX - 15;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// mostly a small cube of the chunk so that neighbours get filled,
	// sometimes around the border, sometimes anywhere in the world
	function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] origin,
			int base);
		int unsigned q;
		q = $urandom_range(0, 99);
		if (q < 10)
			return $urandom;
		if (q < 25)
			return origin + (int'($urandom_range(0, 19)) - 2);
		return origin + base + int'($urandom_range(0, 3));
	endfunction

	// ---------------------------------------------------------------
	// directed script
	// ---------------------------------------------------------------

	function automatic vox_result_t outcome(logic hit, logic [FACE_W-1:0] faces,
			logic [TYPE_W-1:0] ctype, logic solid);
		return {hit, faces, ctype, solid};
	endfunction

	function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
		script_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		script.push_back(row);
	endfunction

	function automatic void item_row(logic [KIND_W-1:0] k, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic [TYPE_W-1:0] nt);
		script_row_t row;
		row = '0;
		row.k = k;
		row.x = x;
		row.y = y;
		row.z = z;
		row.nt = nt;
		script.push_back(row);
	endfunction

	function automatic void pinned_row(logic [KIND_W-1:0] k, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic [TYPE_W-1:0] nt,
			vox_result_t want);
		item_row(k, x, y, z, nt);
		script[$].pinned = 1'b1;
		script[$].want = want;
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: bad %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_item(logic [KIND_W-1:0] k, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
			logic [TYPE_W-1:0] nt, logic pinned, vox_result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		new_type <= nt;
		pin_on = pinned;
		pin_res = want;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// drop valid and wait until every item has come back
	task automatic await_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one register setting followed by a burst of random items
	task automatic run_phase(int p);
		logic [MASK_W-1:0] vm, sm;
		logic signed [COORD_W-1:0] ox, oy, oz;
		logic [KIND_W-1:0] k;
		int bx, by, bz;
		int unsigned r;
		case (p)
			0: begin
				vm = '1;
				sm = '1;
				ox = C_MAX - 15;
				oy = C_MIN;
				oz = '0;
			end
			1: begin
				vm = '0;
				sm = '0;
				ox = C_MIN;
				oy = C_MAX - 15;
				oz = C_MAX;
			end
			default: begin
				vm = pick_mask();
				sm = pick_mask();
				ox = pick_origin();
				oy = pick_origin();
				oz = pick_origin();
			end
		endcase
		await_idle();
		write_reg(REG_VIEWABLE, vm);
		write_reg(REG_SOLID, sm);
		// upper data bits are don't-care for the origins, so make them noisy
		write_reg(REG_ORIGIN_X, {$urandom, ox});
		write_reg(REG_ORIGIN_Y, {$urandom, oy});
		write_reg(REG_ORIGIN_Z, {$urandom, oz});
		// corner 0 and corner 12 touch the chunk border
		bx = 6 * $urandom_range(0, 2);
		by = 6 * $urandom_range(0, 2);
		bz = 6 * $urandom_range(0, 2);
		repeat (105) begin
			r = $urandom_range(0, 99);
			k = r < 40 ? KIND_WRITE : r < 75 ? KIND_FACE : r < 95 ? KIND_SOLID : KIND_UNUSED;
			push_item(k, pick_coord(ox, bx), pick_coord(oy, by), pick_coord(oz, bz),
				$urandom_range(0, 63), 1'b0, '0);
		end
	endtask

	// calm stretches with no idling on either side
	always begin
		repeat ($urandom_range(150, 400)) @(posedge clk);
		calm = 1'b1;
		repeat ($urandom_range(40, 120)) @(posedge clk);
		calm = 1'b0;
	end

	// result backpressure
	initial begin : result_stalls
		int n;
		@(negedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	// ---------------------------------------------------------------
	// result check, prediction at acceptance, watchdog
	// ---------------------------------------------------------------

	always @(posedge clk) begin : result_monitor
		vox_result_t got, want;
		vox_result_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {in_chunk, face_mask, cell_type, solid_hit};
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", got, '0);
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit)
						report_mismatch("in_chunk", got.hit, want.hit);
					if (got.faces !== want.faces)
						report_mismatch("face_mask", got.faces, want.faces);
					if (got.ctype !== want.ctype)
						report_mismatch("cell_type", got.ctype, want.ctype);
					if (got.solid !== want.solid)
						report_mismatch("solid_hit", got.solid, want.solid);
				end
			end
			if (in_valid && !in_stall) begin
				// always run the shadow so writes land even on typed rows
				pred = predict_visibility(kind, pos_x, pos_y, pos_z, new_type);
				pending_results.push_back(pin_on ? pin_res : pred);
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin : stimulus
		script_row_t row;
		// reset state: masks zero, origin at world zero
		pinned_row(KIND_FACE, 0, 0, 0, 0, outcome(1, 0, 0, 0));
		pinned_row(KIND_SOLID, 15, 15, 15, 0, outcome(1, 0, 0, 0));
		// writes just past the x and y borders and at the coordinate extremes are dropped
		pinned_row(KIND_WRITE, 16, 0, 0, 5, outcome(0, 0, 0, 0));
		pinned_row(KIND_WRITE, 0, -1, 0, 5, outcome(0, 0, 0, 0));
		pinned_row(KIND_WRITE, C_MIN, C_MAX, C_MIN, 63, outcome(0, 0, 0, 0));
		pinned_row(KIND_WRITE, 0, 0, 0, 63, outcome(1, 0, 63, 0));
		pinned_row(KIND_WRITE, 1, 0, 0, 1, outcome(1, 0, 1, 0));
		pinned_row(KIND_WRITE, 15, 15, 15, 42, outcome(1, 0, 42, 0));
		// unused kind leaves the chunk alone
		pinned_row(KIND_UNUSED, 0, 0, 0, 7, outcome(0, 0, 0, 0));
		// nothing viewable yet: no faces
		pinned_row(KIND_FACE, 0, 0, 0, 0, outcome(1, 0, 63, 0));
		// everything but void viewable, types 1 and 63 solid
		cfg_row(REG_VIEWABLE, 64'hffff_ffff_ffff_fffe);
		cfg_row(REG_SOLID, 64'h8000_0000_0000_0002);
		item_row(KIND_FACE, 0, 0, 0, 0);
		pinned_row(KIND_SOLID, 0, 0, 0, 0, outcome(1, 0, 63, 1));
		item_row(KIND_FACE, 15, 15, 15, 0);
		item_row(KIND_SOLID, 1, 0, 0, 0);
		pinned_row(KIND_FACE, 5, 5, 5, 0, outcome(1, 0, 0, 0));
		// chunk moved to the far corners of the coordinate range in x and y
		cfg_row(REG_ORIGIN_X, {32'h0, C_MIN});
		cfg_row(REG_ORIGIN_Y, {32'h0, C_MAX});
		cfg_row(REG_ORIGIN_Z, {32'hffff_ffff, -32'sd8});
		item_row(KIND_FACE, C_MIN, C_MAX, -8, 0);
		pinned_row(KIND_WRITE, C_MIN + 15, C_MAX, 7, 9, outcome(1, 0, 9, 0));
		pinned_row(KIND_SOLID, C_MAX, C_MAX, -8, 0, outcome(0, 0, 0, 0));
		pinned_row(KIND_WRITE, C_MIN, C_MAX - 1, -8, 3, outcome(0, 0, 0, 0));
		pinned_row(KIND_FACE, C_MIN + 16, C_MAX, -8, 0, outcome(0, 0, 0, 0));
		item_row(KIND_FACE, C_MIN + 15, C_MAX, 7, 0);
		pinned_row(KIND_SOLID, C_MIN + 15, C_MAX, 7, 0, outcome(1, 0, 9, 0));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			row = script[i];
			if (row.is_cfg) begin
				await_idle();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				push_item(row.k, row.x, row.y, row.z, row.nt, row.pinned, row.want);
			end
		end

		for (int p = 0; p < 8; p++)
			run_phase(p);

		// drain, then leave room for any stray result
		await_idle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
